// ===== design/bbg_pkg.sv =====
// Shared widths, register indexes, reset values and lane type of the gradient pixel block.
package bbg_pkg;

  localparam int CH_W        = 8;
  localparam int NUM_CH      = 3;
  localparam int NUM_CORNERS = 4;
  localparam int COORD_W     = 16;
  localparam int BLEND_W     = 9;
  localparam int BLEND_SHIFT = 8;
  localparam int RGB_W       = NUM_CH * CH_W;
  localparam int PAIR_W      = 2 * RGB_W;
  localparam int CFG_IDX_W   = 3;
  localparam int QUO_W       = 8;
  localparam int DIV_NUM_W   = CH_W + COORD_W;

  localparam logic [BLEND_W-1:0] BLEND_FULL = 9'd256;

  localparam logic [CFG_IDX_W-1:0] REG_TOP_LEFT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_RIGHT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_LEFT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_RIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS         = 3'd5;

  localparam logic [PAIR_W-1:0]  RST_TOP_LEFT     = 48'hFF0000FFFF00;
  localparam logic [PAIR_W-1:0]  RST_TOP_RIGHT    = 48'h00FF0000FFFF;
  localparam logic [PAIR_W-1:0]  RST_BOTTOM_LEFT  = 48'h0000FFFF00FF;
  localparam logic [PAIR_W-1:0]  RST_BOTTOM_RIGHT = 48'hFFFFFFFFFFFF;
  localparam logic [COORD_W-1:0] RST_COLUMNS      = 16'd80;
  localparam logic [COORD_W-1:0] RST_ROWS         = 16'd24;

  typedef logic [CH_W-1:0] chan_t;

  // One interpolation: magnitude of (b - a) * num, its sign, and the start value a.
  typedef struct packed {
    logic [DIV_NUM_W-1:0] mag;
    logic                 neg;
    chan_t                base;
  } div_lane_t;

endpackage

// ===== design/bbg_div.sv =====
// Pipelined floor-divide-and-add unit: base + floor(+-mag / divisor), two quotient bits a stage.
module bbg_div #(
  parameter int LANES  = 6,
  parameter int SIDE_W = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [bbg_pkg::COORD_W-1:0] divisor_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  bbg_pkg::div_lane_t          in_lane_i [LANES],
  input  logic [SIDE_W-1:0]           in_side_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output bbg_pkg::chan_t              out_color_o [LANES],
  output logic [SIDE_W-1:0]           out_side_o
);
  import bbg_pkg::*;

  localparam int STEPS = 2;
  localparam int ST    = QUO_W / STEPS;
  localparam int S_ALL = ST + 1;
  localparam int QB    = $clog2(QUO_W);

  logic [S_ALL-1:0]     valid_q;
  logic [S_ALL:0]       ready;
  logic [DIV_NUM_W-1:0] rem_q  [ST][LANES];
  logic [QUO_W-1:0]     quo_q  [ST][LANES];
  logic                 neg_q  [ST][LANES];
  chan_t                base_q [ST][LANES];
  logic [SIDE_W-1:0]    side_q [S_ALL];
  chan_t                color_q [LANES];
  chan_t                color_d [LANES];

  assign ready[S_ALL] = out_ready_i;
  assign in_ready_o   = ready[0];

  for (genvar s = 0; s < S_ALL; s++) begin : g_ready
    assign ready[s] = !valid_q[s] || ready[s+1];
  end

  for (genvar s = 0; s < ST; s++) begin : g_step
    logic [DIV_NUM_W-1:0] rem_src  [LANES];
    logic [QUO_W-1:0]     quo_src  [LANES];
    logic                 neg_src  [LANES];
    chan_t                base_src [LANES];
    logic [SIDE_W-1:0]    side_src;
    logic                 valid_src;
    logic [DIV_NUM_W-1:0] rem_d    [LANES];
    logic [QUO_W-1:0]     quo_d    [LANES];

    if (s == 0) begin : g_first
      always_comb begin
        for (int l = 0; l < LANES; l++) begin
          rem_src[l]  = in_lane_i[l].mag;
          quo_src[l]  = '0;
          neg_src[l]  = in_lane_i[l].neg;
          base_src[l] = in_lane_i[l].base;
        end
        side_src  = in_side_i;
        valid_src = in_valid_i;
      end
    end else begin : g_next
      always_comb begin
        for (int l = 0; l < LANES; l++) begin
          rem_src[l]  = rem_q[s-1][l];
          quo_src[l]  = quo_q[s-1][l];
          neg_src[l]  = neg_q[s-1][l];
          base_src[l] = base_q[s-1][l];
        end
        side_src  = side_q[s-1];
        valid_src = valid_q[s-1];
      end
    end

    // restoring steps, most significant quotient bit first
    always_comb begin
      int                   k;
      logic [DIV_NUM_W-1:0] dsh;
      for (int l = 0; l < LANES; l++) begin
        rem_d[l] = rem_src[l];
        quo_d[l] = quo_src[l];
        for (int j = 0; j < STEPS; j++) begin
          k   = QUO_W - 1 - s * STEPS - j;
          dsh = DIV_NUM_W'(divisor_i) << k;
          if (rem_d[l] >= dsh) begin
            rem_d[l]          = rem_d[l] - dsh;
            quo_d[l][QB'(k)]  = 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (ready[s]) begin
        valid_q[s] <= valid_src;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ready[s] && valid_src) begin
        rem_q[s]  <= rem_d;
        quo_q[s]  <= quo_d;
        neg_q[s]  <= neg_src;
        base_q[s] <= base_src;
        side_q[s] <= side_src;
      end
    end
  end

  // floor correction for negative quotients, then add the start value
  always_comb begin
    logic [CH_W+1:0] sum;
    logic            nz;
    for (int l = 0; l < LANES; l++) begin
      nz = |rem_q[ST-1][l];
      if (neg_q[ST-1][l]) begin
        sum = {2'b00, base_q[ST-1][l]} - {2'b00, quo_q[ST-1][l]} - {{(CH_W+1){1'b0}}, nz};
      end else begin
        sum = {2'b00, base_q[ST-1][l]} + {2'b00, quo_q[ST-1][l]};
      end
      color_d[l] = sum[CH_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[ST] <= 1'b0;
    end else if (ready[ST]) begin
      valid_q[ST] <= valid_q[ST-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready[ST] && valid_q[ST-1]) begin
      color_q    <= color_d;
      side_q[ST] <= side_q[ST-1];
    end
  end

  assign out_valid_o = valid_q[ST];
  assign out_color_o = color_q;
  assign out_side_o  = side_q[ST];

endmodule

// ===== design/blended_bilinear_gradient_pixel.sv =====
// Top level: blended four-corner bilinear gradient, one pixel word per clock while the output is not stalled.
// Registers in order: stage A, stage B, stage C, the horizontal divider, stage D, the vertical divider.
// Throughput: one word per cycle unless the output stalls; the two pipelined dividers (horizontal by
// columns, vertical by rows, two quotient bits a stage) make up most of the depth.
// Each stage holds its own valid bit, so bubbles close up under output stall.
// Reset (rst_ni low, async) empties the pipe and loads the default corner colors,
// columns = 80 and rows = 24.
module blended_bilinear_gradient_pixel (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bbg_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bbg_pkg::PAIR_W-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [bbg_pkg::COORD_W-1:0]   column_i,
  input  logic [bbg_pkg::COORD_W-1:0]   row_i,
  input  logic [bbg_pkg::BLEND_W-1:0]   blend_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [bbg_pkg::CH_W-1:0]      red_o,
  output logic [bbg_pkg::CH_W-1:0]      green_o,
  output logic [bbg_pkg::CH_W-1:0]      blue_o
);
  import bbg_pkg::*;

  localparam int NUM_LANES_H = 2 * NUM_CH;
  localparam int PW          = CH_W + BLEND_W + 3;

  // ---------------------------------------------------------------- config
  logic [PAIR_W-1:0]  pair_q [NUM_CORNERS];
  logic [COORD_W-1:0] columns_q, rows_q;
  logic [COORD_W-1:0] width, height;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_q[0] <= RST_TOP_LEFT;
      pair_q[1] <= RST_TOP_RIGHT;
      pair_q[2] <= RST_BOTTOM_LEFT;
      pair_q[3] <= RST_BOTTOM_RIGHT;
      columns_q <= RST_COLUMNS;
      rows_q    <= RST_ROWS;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_TOP_LEFT:     pair_q[0] <= cfg_wdata_i;
        REG_TOP_RIGHT:    pair_q[1] <= cfg_wdata_i;
        REG_BOTTOM_LEFT:  pair_q[2] <= cfg_wdata_i;
        REG_BOTTOM_RIGHT: pair_q[3] <= cfg_wdata_i;
        REG_COLUMNS:      columns_q <= cfg_wdata_i[COORD_W-1:0];
        REG_ROWS:         rows_q    <= cfg_wdata_i[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  // a zero divisor acts as one
  assign width  = (columns_q == '0) ? COORD_W'(1) : columns_q;
  assign height = (rows_q == '0) ? COORD_W'(1) : rows_q;

  // ------------------------------------------------------ stage A: clamp
  logic               a_valid_q, a_ready;
  logic [BLEND_W-1:0] a_blend_q;
  logic [COORD_W-1:0] a_x_q, a_y_q;
  logic               b_valid_q, b_ready;
  logic               c_valid_q, c_ready;
  logic               h_in_ready;

  assign a_ready    = !a_valid_q || b_ready;
  assign in_ready_o = a_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_ready) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && in_valid_i) begin
      a_blend_q <= (blend_i > BLEND_FULL) ? BLEND_FULL : blend_i;
      a_x_q     <= (column_i > width) ? width : column_i;
      a_y_q     <= (row_i > height) ? height : row_i;
    end
  end

  // ----------------------------------------- stage B: blend each corner pair
  chan_t              b_corner_q [NUM_CORNERS][NUM_CH];
  chan_t              b_corner_d [NUM_CORNERS][NUM_CH];
  logic [COORD_W-1:0] b_x_q, b_y_q;

  assign b_ready = !b_valid_q || c_ready;

  always_comb begin
    logic signed [CH_W:0]    dlt;
    logic signed [BLEND_W:0] tw;
    logic signed [PW-1:0]    prod;
    logic signed [PW-1:0]    sum;
    chan_t                   first, second;
    tw = $signed({1'b0, a_blend_q});
    for (int c = 0; c < NUM_CORNERS; c++) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        first  = pair_q[c][RGB_W + (NUM_CH-1-ch)*CH_W +: CH_W];
        second = pair_q[c][(NUM_CH-1-ch)*CH_W +: CH_W];
        dlt    = $signed({1'b0, second}) - $signed({1'b0, first});
        prod   = dlt * tw;
        // arithmetic shift gives the floor of the signed quotient
        sum    = $signed({{(PW-CH_W){1'b0}}, first}) + (prod >>> BLEND_SHIFT);
        b_corner_d[c][ch] = sum[CH_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_ready) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_ready && a_valid_q) begin
      b_corner_q <= b_corner_d;
      b_x_q      <= a_x_q;
      b_y_q      <= a_y_q;
    end
  end

  // ----------------------------- stage C: horizontal difference times column
  // lane ch: top edge of channel ch; lane NUM_CH + ch: bottom edge
  div_lane_t          c_lane_q [NUM_LANES_H];
  div_lane_t          c_lane_d [NUM_LANES_H];
  logic [COORD_W-1:0] c_y_q;

  assign c_ready = !c_valid_q || h_in_ready;

  always_comb begin
    logic signed [CH_W:0] dlt;
    logic [CH_W:0]        absd;
    chan_t                left, right;
    for (int e = 0; e < 2; e++) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        left  = b_corner_q[2*e][ch];
        right = b_corner_q[2*e+1][ch];
        dlt   = $signed({1'b0, right}) - $signed({1'b0, left});
        absd  = dlt[CH_W] ? $unsigned(-dlt) : $unsigned(dlt);
        c_lane_d[e*NUM_CH+ch].mag  = DIV_NUM_W'(absd[CH_W-1:0]) * DIV_NUM_W'(b_x_q);
        c_lane_d[e*NUM_CH+ch].neg  = dlt[CH_W];
        c_lane_d[e*NUM_CH+ch].base = left;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (c_ready) begin
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_ready && b_valid_q) begin
      c_lane_q <= c_lane_d;
      c_y_q    <= b_y_q;
    end
  end

  // ------------------------------------------- horizontal divide by columns
  logic               h_valid;
  logic               d_ready;
  chan_t              h_color [NUM_LANES_H];
  logic [COORD_W-1:0] h_y;

  bbg_div #(
    .LANES  (NUM_LANES_H),
    .SIDE_W (COORD_W)
  ) u_div_h (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .divisor_i   (width),
    .in_valid_i  (c_valid_q),
    .in_ready_o  (h_in_ready),
    .in_lane_i   (c_lane_q),
    .in_side_i   (c_y_q),
    .out_valid_o (h_valid),
    .out_ready_i (d_ready),
    .out_color_o (h_color),
    .out_side_o  (h_y)
  );

  // ---------------------------------- stage D: vertical difference times row
  logic      d_valid_q;
  logic      v_in_ready;
  div_lane_t d_lane_q [NUM_CH];
  div_lane_t d_lane_d [NUM_CH];

  assign d_ready = !d_valid_q || v_in_ready;

  always_comb begin
    logic signed [CH_W:0] dlt;
    logic [CH_W:0]        absd;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      dlt  = $signed({1'b0, h_color[NUM_CH+ch]}) - $signed({1'b0, h_color[ch]});
      absd = dlt[CH_W] ? $unsigned(-dlt) : $unsigned(dlt);
      d_lane_d[ch].mag  = DIV_NUM_W'(absd[CH_W-1:0]) * DIV_NUM_W'(h_y);
      d_lane_d[ch].neg  = dlt[CH_W];
      d_lane_d[ch].base = h_color[ch];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_valid_q <= 1'b0;
    end else if (d_ready) begin
      d_valid_q <= h_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (d_ready && h_valid) begin
      d_lane_q <= d_lane_d;
    end
  end

  // ------------------------------------------------ vertical divide by rows
  // its last stage is the output register
  chan_t v_color [NUM_CH];

  bbg_div #(
    .LANES  (NUM_CH),
    .SIDE_W (1)
  ) u_div_v (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .divisor_i   (height),
    .in_valid_i  (d_valid_q),
    .in_ready_o  (v_in_ready),
    .in_lane_i   (d_lane_q),
    .in_side_i   (1'b0),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_color_o (v_color),
    .out_side_o  ()
  );

  assign red_o   = v_color[0];
  assign green_o = v_color[1];
  assign blue_o  = v_color[2];

endmodule

// ===== design/bbg_checker.sv =====
// Port-level checker for the gradient pixel block, bound to the top level.
module bbg_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          cfg_we_i,
  input logic [bbg_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input logic [bbg_pkg::PAIR_W-1:0]    cfg_wdata_i,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic [bbg_pkg::COORD_W-1:0]   column_i,
  input logic [bbg_pkg::COORD_W-1:0]   row_i,
  input logic [bbg_pkg::BLEND_W-1:0]   blend_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [bbg_pkg::CH_W-1:0]      red_o,
  input logic [bbg_pkg::CH_W-1:0]      green_o,
  input logic [bbg_pkg::CH_W-1:0]      blue_o
);

  // a stalled result word stays up
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // and keeps its color
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(red_o) && $stable(green_o) && $stable(blue_o))
    else $error("result word changed while stalled");

  // input backpressure only when the pipe is full behind a stalled output
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled with room in the pipe");

  // a taken output with nothing entering cannot block the next input
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i |-> in_ready_o)
    else $error("input not ready while output drains");

endmodule

bind blended_bilinear_gradient_pixel bbg_checker u_bbg_checker (.*);

// ===== dv/tb_blended_bilinear_gradient_pixel.sv =====
// Self-checking bench for the blended bilinear gradient pixel block: directed table then random phases.
module tb_blended_bilinear_gradient_pixel;
  timeunit 1ns;
  timeprecision 1ps;

  import bbg_pkg::*;

  // Run shape. The guard outlasts the pipe depth with margin before registers are
  // touched. The watchdog outlasts the longest sender gap plus the longest receiver
  // stall plus the pipe depth many times over.
  localparam int RANDOM_ITEMS   = 1100;
  localparam int PIPE_GUARD     = 20;
  localparam int WATCHDOG_LIMIT = 3000;

  typedef struct packed {
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
    logic [BLEND_W-1:0] blend;
  } pixel_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } color_t;

  // One directed row: the word to send, and a typed-in color where it is obvious.
  typedef struct packed {
    pixel_t px;
    logic   known;
    color_t rgb;
  } vec_t;

  localparam int TABLE_LEN = 21;

  // All rows run on the reset registers: 80 columns, 24 rows, corners
  // TL red/yellow, TR green/cyan, BL blue/magenta, BR white/white.
  localparam vec_t PIXEL_TABLE [TABLE_LEN] = '{
    // each corner with its first set, and the top left with its second set
    '{'{16'd0,     16'd0,     9'd0},   1'b1, '{8'hFF, 8'h00, 8'h00}},
    '{'{16'd0,     16'd0,     9'd256}, 1'b1, '{8'hFF, 8'hFF, 8'h00}},
    '{'{16'd80,    16'd0,     9'd0},   1'b1, '{8'h00, 8'hFF, 8'h00}},
    '{'{16'd0,     16'd24,    9'd0},   1'b1, '{8'h00, 8'h00, 8'hFF}},
    '{'{16'd80,    16'd24,    9'd0},   1'b1, '{8'hFF, 8'hFF, 8'hFF}},
    // blend above full scale clamps to the second set
    '{'{16'd0,     16'd0,     9'd511}, 1'b1, '{8'hFF, 8'hFF, 8'h00}},
    '{'{16'd81,    16'd25,    9'd300}, 1'b1, '{8'hFF, 8'hFF, 8'hFF}},
    // coordinates past the edge clamp to the edge
    '{'{16'hFFFF,  16'd0,     9'd256}, 1'b1, '{8'h00, 8'hFF, 8'hFF}},
    '{'{16'd0,     16'hFFFF,  9'd256}, 1'b1, '{8'hFF, 8'h00, 8'hFF}},
    '{'{16'hFFFF,  16'hFFFF,  9'd257}, 1'b1, '{8'hFF, 8'hFF, 8'hFF}},
    '{'{16'd65534, 16'd0,     9'd0},   1'b1, '{8'h00, 8'hFF, 8'h00}},
    '{'{16'd0,     16'd65534, 9'd0},   1'b1, '{8'h00, 8'h00, 8'hFF}},
    '{'{16'h5555,  16'hAAAA,  9'h155}, 1'b1, '{8'hFF, 8'hFF, 8'hFF}},
    // interior, edge and clamped points: floor rounding on falling and rising slopes
    '{'{16'd79,    16'd23,    9'd255}, 1'b0, '0},
    '{'{16'd40,    16'd12,    9'd128}, 1'b0, '0},
    '{'{16'd1,     16'd1,     9'd1},   1'b0, '0},
    '{'{16'd20,    16'd0,     9'd0},   1'b0, '0},
    '{'{16'd60,    16'd6,     9'd64},  1'b0, '0},
    '{'{16'd0,     16'd12,    9'd0},   1'b0, '0},
    '{'{16'd33,    16'd17,    9'd200}, 1'b0, '0},
    '{'{16'hAAAA,  16'h5555,  9'h0AA}, 1'b0, '0}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [PAIR_W-1:0]     cfg_wdata = '0;
  logic                  pix_valid = 1'b0;
  pixel_t                pix_word = '0;
  logic                  pix_known = 1'b0;
  color_t                pix_known_rgb = '0;
  logic                  rgb_ready = 1'b0;
  logic                  in_ready;
  logic                  rgb_valid;
  chan_t                 red, green, blue;

  // Shadow of the register file, kept by the write task.
  logic [PAIR_W-1:0]     corner_pairs [NUM_CORNERS];
  logic [COORD_W-1:0]    span_x;
  logic [COORD_W-1:0]    span_y;

  color_t                pending_colors [$];
  int                    fail_count = 0;
  int                    idle_cycles = 0;
  int                    rx_stall_left = 0;
  bit                    calm = 1'b0;
  string                 lane_names [3] = '{"blue", "green", "red"};

  blended_bilinear_gradient_pixel uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (pix_valid),
    .in_ready_o  (in_ready),
    .column_i    (pix_word.column),
    .row_i       (pix_word.row),
    .blend_i     (pix_word.blend),
    .out_valid_o (rgb_valid),
    .out_ready_i (rgb_ready),
    .red_o       (red),
    .green_o     (green),
    .blue_o      (blue)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    corner_pairs[0] = RST_TOP_LEFT;
    corner_pairs[1] = RST_TOP_RIGHT;
    corner_pairs[2] = RST_BOTTOM_LEFT;
    corner_pairs[3] = RST_BOTTOM_RIGHT;
    span_x = RST_COLUMNS;
    span_y = RST_ROWS;
  end

  // a + floor((b - a) * num / den); integer division truncates, so fix up negatives.
  function automatic int lerp8(int a, int b, int num, int den);
    int n;
    int q;
    n = (b - a) * num;
    q = n / den;
    if ((n % den) != 0 && n < 0) q -= 1;
    return a + q;
  endfunction

  // Color of one pixel: blend each corner pair, then top/bottom edges by x, then by y.
  function automatic color_t shade_pixel(pixel_t px);
    int          x, y, t, w, h;
    int          cc [NUM_CORNERS];
    int          top, bot, c;
    logic [23:0] first, second;
    color_t      rgb;
    w = (span_x == 0) ? 1 : int'(span_x);
    h = (span_y == 0) ? 1 : int'(span_y);
    t = (px.blend > BLEND_FULL) ? 256 : int'(px.blend);
    x = (int'(px.column) > w) ? w : int'(px.column);
    y = (int'(px.row) > h) ? h : int'(px.row);
    rgb = '0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      for (int k = 0; k < NUM_CORNERS; k++) begin
        first  = corner_pairs[k][PAIR_W-1:RGB_W];
        second = corner_pairs[k][RGB_W-1:0];
        cc[k] = lerp8(int'(first[(2-ch)*8 +: 8]), int'(second[(2-ch)*8 +: 8]), t, 256);
      end
      top = lerp8(cc[0], cc[1], x, w);
      bot = lerp8(cc[2], cc[3], x, w);
      c   = lerp8(top, bot, y, h);
      rgb[(2-ch)*8 +: 8] = c[7:0];
    end
    return rgb;
  endfunction

  // Gap length: mostly none, some short, a few long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Coordinate against a divisor: mostly in range, plus edge, past-edge and full-width values.
  function automatic logic [COORD_W-1:0] pick_coord(logic [COORD_W-1:0] lim);
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return (lim <= 1) ? '0 : COORD_W'($urandom_range(0, int'(lim) - 1));
    if (r < 83) return lim;
    if (r < 88) return lim + 1'b1;
    if (r < 92) return '0;
    if (r < 96) return '1;
    return COORD_W'($urandom_range(0, 65535));
  endfunction

  function automatic logic [BLEND_W-1:0] pick_blend();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return BLEND_W'($urandom_range(0, 256));
    if (r < 88) return $urandom_range(0, 1) ? BLEND_FULL : '0;
    return BLEND_W'($urandom_range(257, 511));
  endfunction

  function automatic logic [PAIR_W-1:0] pick_pair();
    int                r;
    logic [PAIR_W-1:0] p;
    r = $urandom_range(0, 99);
    if (r < 55) return PAIR_W'({$urandom, $urandom});
    if (r < 65) return '0;
    if (r < 75) return '1;
    for (int k = 0; k < 6; k++) p[k*8 +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return p;
  endfunction

  function automatic logic [COORD_W-1:0] pick_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return COORD_W'($urandom_range(1, 8));
    if (r < 50) return COORD_W'($urandom_range(9, 300));
    if (r < 65) return COORD_W'($urandom_range(0, 65535));
    if (r < 75) return $urandom_range(0, 1) ? RST_COLUMNS : RST_ROWS;
    if (r < 85) return '1;
    if (r < 92) return '0;
    return COORD_W'(1);
  endfunction

  // Bits above the 16-bit registers must be dropped by the block.
  function automatic logic [31:0] upper_noise();
    return $urandom_range(0, 1) ? 32'($urandom) : 32'h0;
  endfunction

  // One register write word; the shadow follows at once since the pipe is empty.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PAIR_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_TOP_LEFT:     corner_pairs[0] = val;
      REG_TOP_RIGHT:    corner_pairs[1] = val;
      REG_BOTTOM_LEFT:  corner_pairs[2] = val;
      REG_BOTTOM_RIGHT: corner_pairs[3] = val;
      REG_COLUMNS:      span_x = val[COORD_W-1:0];
      REG_ROWS:         span_y = val[COORD_W-1:0];
      default: ;
    endcase
  endtask

  // Offer one pixel word after an optional gap and hold it until taken.
  task automatic send_pixel(input pixel_t px, input logic known, input color_t rgb,
                            input int gap);
    repeat (gap) begin
      @(negedge clk);
      pix_valid <= 1'b0;
    end
    @(negedge clk);
    pix_valid     <= 1'b1;
    pix_word      <= px;
    pix_known     <= known;
    pix_known_rgb <= rgb;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
  endtask

  // Stop sending, wait for every expected color to come out, then wait out the pipe guard.
  task automatic drain_pipe();
    @(negedge clk);
    pix_valid <= 1'b0;
    while (pending_colors.size() != 0) @(posedge clk);
    repeat (PIPE_GUARD) @(posedge clk);
  endtask

  // Receiver: ready drops for random stretches unless the phase is calm.
  always @(negedge clk) begin
    if (rx_stall_left > 0) begin
      rgb_ready <= 1'b0;
      rx_stall_left--;
    end else begin
      rgb_ready <= 1'b1;
      if (!calm && $urandom_range(0, 99) < 25) rx_stall_left = pick_gap();
    end
  end

  // Scoreboard and watchdog, all on the rising edge. Accepted inputs queue
  // their color first, then the output word is checked against the oldest one.
  always @(posedge clk) begin : scoreboard
    color_t want;
    color_t got;
    logic   took_in;
    logic   took_out;
    if (rst_n) begin
      took_in  = pix_valid && (in_ready === 1'b1);
      took_out = (rgb_valid === 1'b1) && rgb_ready;
      if (took_in) pending_colors.push_back(pix_known ? pix_known_rgb : shade_pixel(pix_word));
      if (took_out) begin
        got = '{red, green, blue};
        if (pending_colors.size() == 0) begin
          fail_count++;
          $display("%0t: color word %06h with none expected", $time, got);
        end else begin
          want = pending_colors.pop_front();
          for (int i = 0; i < NUM_CH; i++) begin
            if (got[i*8 +: 8] !== want[i*8 +: 8]) begin
              fail_count++;
              $display("%0t: %s mismatch, expected %02h, actual %02h", $time, lane_names[i],
                       want[i*8 +: 8], got[i*8 +: 8]);
            end
          end
        end
      end
      if (took_in || took_out) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
        $display("** blended_bilinear_gradient_pixel: FAILED **");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int     sent;
    int     phase;
    int     burst;
    pixel_t px;
    sent  = 0;
    phase = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table on the reset registers, with a few gaps mixed in.
    for (int i = 0; i < TABLE_LEN; i++) begin
      send_pixel(PIXEL_TABLE[i].px, PIXEL_TABLE[i].known, PIXEL_TABLE[i].rgb,
                 (i % 4 == 3) ? 2 : 0);
    end
    drain_pipe();

    // Random phases: new registers while idle, then a burst of pixel words.
    while (sent < RANDOM_ITEMS) begin
      case (phase)
        0: begin
          // widest divisors, random corners
          write_reg(REG_TOP_LEFT, pick_pair());
          write_reg(REG_TOP_RIGHT, pick_pair());
          write_reg(REG_BOTTOM_LEFT, pick_pair());
          write_reg(REG_BOTTOM_RIGHT, pick_pair());
          write_reg(REG_COLUMNS, {upper_noise(), 16'hFFFF});
          write_reg(REG_ROWS, {upper_noise(), 16'hFFFF});
        end
        1: begin
          // zero divisors fall back to one; corners at full black and white
          write_reg(REG_TOP_LEFT, '0);
          write_reg(REG_TOP_RIGHT, '1);
          write_reg(REG_BOTTOM_LEFT, '1);
          write_reg(REG_BOTTOM_RIGHT, '0);
          write_reg(REG_COLUMNS, {upper_noise(), 16'd0});
          write_reg(REG_ROWS, {upper_noise(), 16'd0});
        end
        2: begin
          // one-pixel divisors; writes to unused indexes must change nothing
          write_reg(REG_COLUMNS, {upper_noise(), 16'd1});
          write_reg(REG_ROWS, {upper_noise(), 16'd1});
          write_reg(CFG_IDX_W'(6), PAIR_W'({$urandom, $urandom}));
          write_reg(CFG_IDX_W'(7), PAIR_W'({$urandom, $urandom}));
          write_reg(REG_TOP_LEFT, pick_pair());
        end
        default: begin
          if ($urandom_range(0, 9) < 6) write_reg(REG_TOP_LEFT, pick_pair());
          if ($urandom_range(0, 9) < 6) write_reg(REG_TOP_RIGHT, pick_pair());
          if ($urandom_range(0, 9) < 6) write_reg(REG_BOTTOM_LEFT, pick_pair());
          if ($urandom_range(0, 9) < 6) write_reg(REG_BOTTOM_RIGHT, pick_pair());
          if ($urandom_range(0, 9) < 6) write_reg(REG_COLUMNS, {upper_noise(), pick_span()});
          if ($urandom_range(0, 9) < 6) write_reg(REG_ROWS, {upper_noise(), pick_span()});
          if ($urandom_range(0, 9) == 0) write_reg(CFG_IDX_W'($urandom_range(6, 7)),
                                                   PAIR_W'({$urandom, $urandom}));
        end
      endcase
      @(negedge clk);
      cfg_we <= 1'b0;

      // some phases run back to back on both sides
      calm  = (phase == 3) || ($urandom_range(0, 99) < 15);
      burst = $urandom_range(60, 120);
      repeat (burst) begin
        if (!calm && $urandom_range(0, 199) == 0) drain_pipe();
        px.column = pick_coord(span_x);
        px.row    = pick_coord(span_y);
        px.blend  = pick_blend();
        send_pixel(px, 1'b0, '0, calm ? 0 : pick_gap());
        sent++;
      end
      drain_pipe();
      phase++;
    end

    if (fail_count == 0) begin
      $display("** blended_bilinear_gradient_pixel: PASSED **");
    end else begin
      $display("** blended_bilinear_gradient_pixel: FAILED **");
    end
    $finish;
  end

endmodule
